@@ design/servo_command_slew_shaper_defines.svh @@
// ----------------------------------------------------------------------------
// Servo command slew shaper assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SERVO_COMMAND_SLEW_SHAPER_DEFINES_SVH
`define SERVO_COMMAND_SLEW_SHAPER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SVCS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SVCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/svcs_pkg.sv @@
// ----------------------------------------------------------------------------
// Servo command slew shaper package
// Field widths, reset values, request and register codes and the
// configuration bundle shared by the register file and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package svcs_pkg;

   // Default number of fraction bits of the pulse fixed-point format.
   localparam int FRAC_BITS_DEFAULT = 8;

   // Field widths.
   localparam int PULSE_W    = 12;
   localparam int TRAVEL_W   = 11;
   localparam int LIMIT_W    = 15;
   localparam int RATE_W     = 16;
   localparam int INTERVAL_W = 8;
   localparam int CMD_W      = 16;
   localparam int CMD_FRAC   = 15;
   localparam int ELAPSED_W  = 10;
   localparam int ACCUM_W    = 16;
   localparam int REQ_W      = 2;

   // Port widths.
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Commands whose magnitude is below this count are treated as zero.
   localparam int DEADBAND = 164;

   // Register reset values.
   localparam logic [PULSE_W-1:0]    NEUTRAL_RESET   = 12'd1500;
   localparam logic [PULSE_W-1:0]    MIN_RESET       = 12'd1000;
   localparam logic [PULSE_W-1:0]    MAX_RESET       = 12'd2000;
   localparam logic [TRAVEL_W-1:0]   TRAVEL_RESET    = 11'd500;
   localparam logic                  REVERSED_RESET  = 1'b0;
   localparam logic [LIMIT_W-1:0]    LIMIT_RESET     = 15'd32767;
   localparam logic [RATE_W-1:0]     RATE_RESET      = 16'd512;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET  = 8'd20;

   // Request kinds carried on the input tuser.
   typedef enum logic [REQ_W-1:0] {
      REQ_COMMAND = 2'd0,
      REQ_TICK    = 2'd1,
      REQ_NEUTRAL = 2'd2
   } req_kind_type;

   // Register indexes, one 32-bit word apart.
   typedef enum logic [2:0] {
      REG_NEUTRAL  = 3'd0,
      REG_MIN      = 3'd1,
      REG_MAX      = 3'd2,
      REG_TRAVEL   = 3'd3,
      REG_REVERSED = 3'd4,
      REG_LIMIT    = 3'd5,
      REG_RATE     = 3'd6,
      REG_INTERVAL = 3'd7
   } reg_index_type;

   // Configuration bundle from the register file to the datapath.
   typedef struct packed {
      logic [PULSE_W-1:0]    neutral_pulse;
      logic [PULSE_W-1:0]    min_pulse;
      logic [PULSE_W-1:0]    max_pulse;
      logic [TRAVEL_W-1:0]   brake_travel;
      logic                  direction_reversed;
      logic [LIMIT_W-1:0]    command_limit;
      logic [RATE_W-1:0]     slew_rate;
      logic [INTERVAL_W-1:0] update_interval;
   } cfg_type;

endpackage

`default_nettype wire

@@ design/svcs_csr.sv @@
// ----------------------------------------------------------------------------
// Servo command slew shaper register file
// APB-style configuration registers with fixed reset values and read-back.
// ----------------------------------------------------------------------------
`default_nettype none

module svcs_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [svcs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [svcs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [svcs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready,
   output svcs_pkg::cfg_type                      cfg
);

   svcs_pkg::cfg_type       cfg_ff;
   svcs_pkg::reg_index_type index;
   logic                    write_en;

   // A word is written in the access phase; the port never waits.
   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign index      = svcs_pkg::reg_index_type'(csr_paddr[4:2]);

   // Register storage.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.neutral_pulse      <= svcs_pkg::NEUTRAL_RESET;
         cfg_ff.min_pulse          <= svcs_pkg::MIN_RESET;
         cfg_ff.max_pulse          <= svcs_pkg::MAX_RESET;
         cfg_ff.brake_travel       <= svcs_pkg::TRAVEL_RESET;
         cfg_ff.direction_reversed <= svcs_pkg::REVERSED_RESET;
         cfg_ff.command_limit      <= svcs_pkg::LIMIT_RESET;
         cfg_ff.slew_rate          <= svcs_pkg::RATE_RESET;
         cfg_ff.update_interval    <= svcs_pkg::INTERVAL_RESET;
      end else if (write_en) begin
         case (index)
            svcs_pkg::REG_NEUTRAL: begin
               cfg_ff.neutral_pulse <= csr_pwdata[svcs_pkg::PULSE_W-1:0];
            end
            svcs_pkg::REG_MIN: begin
               cfg_ff.min_pulse <= csr_pwdata[svcs_pkg::PULSE_W-1:0];
            end
            svcs_pkg::REG_MAX: begin
               cfg_ff.max_pulse <= csr_pwdata[svcs_pkg::PULSE_W-1:0];
            end
            svcs_pkg::REG_TRAVEL: begin
               cfg_ff.brake_travel <= csr_pwdata[svcs_pkg::TRAVEL_W-1:0];
            end
            svcs_pkg::REG_REVERSED: begin
               cfg_ff.direction_reversed <= csr_pwdata[0];
            end
            svcs_pkg::REG_LIMIT: begin
               cfg_ff.command_limit <= csr_pwdata[svcs_pkg::LIMIT_W-1:0];
            end
            svcs_pkg::REG_RATE: begin
               cfg_ff.slew_rate <= csr_pwdata[svcs_pkg::RATE_W-1:0];
            end
            svcs_pkg::REG_INTERVAL: begin
               cfg_ff.update_interval <= csr_pwdata[svcs_pkg::INTERVAL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Read-back, zero-extended to the data width.
   always_comb begin
      case (index)
         svcs_pkg::REG_NEUTRAL:  csr_prdata = svcs_pkg::CSR_DATA_W'(cfg_ff.neutral_pulse);
         svcs_pkg::REG_MIN:      csr_prdata = svcs_pkg::CSR_DATA_W'(cfg_ff.min_pulse);
         svcs_pkg::REG_MAX:      csr_prdata = svcs_pkg::CSR_DATA_W'(cfg_ff.max_pulse);
         svcs_pkg::REG_TRAVEL:   csr_prdata = svcs_pkg::CSR_DATA_W'(cfg_ff.brake_travel);
         svcs_pkg::REG_REVERSED: csr_prdata = svcs_pkg::CSR_DATA_W'(cfg_ff.direction_reversed);
         svcs_pkg::REG_LIMIT:    csr_prdata = svcs_pkg::CSR_DATA_W'(cfg_ff.command_limit);
         svcs_pkg::REG_RATE:     csr_prdata = svcs_pkg::CSR_DATA_W'(cfg_ff.slew_rate);
         svcs_pkg::REG_INTERVAL: csr_prdata = svcs_pkg::CSR_DATA_W'(cfg_ff.update_interval);
         default:                csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ design/svcs_core.sv @@
// ----------------------------------------------------------------------------
// Servo command slew shaper datapath
// Input register, single-pass command shaping and slew update, channel state
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "servo_command_slew_shaper_defines.svh"

module svcs_core #(
   parameter int FRAC_BITS = svcs_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire svcs_pkg::cfg_type                 cfg,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [svcs_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic [svcs_pkg::REQ_W-1:0]        req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [svcs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                                   rsp_tuser
);

   localparam int POS_W   = svcs_pkg::PULSE_W + FRAC_BITS;
   localparam int SHIFT   = svcs_pkg::CMD_FRAC - FRAC_BITS;
   localparam int CLIP_W  = svcs_pkg::CMD_W + 1;
   localparam int PROD_W  = svcs_pkg::TRAVEL_W + 1 + CLIP_W;
   localparam int SUM_W   = POS_W + 2;
   localparam int SLEW_W  = svcs_pkg::RATE_W + svcs_pkg::ACCUM_W + FRAC_BITS;
   localparam int RATE_FRAC = 8;

   localparam logic signed [PROD_W-1:0] TRAVEL_BIAS = PROD_W'(2 ** (SHIFT - 1));
   localparam logic [POS_W:0]           PULSE_BIAS  = (POS_W + 1)'(2 ** (FRAC_BITS - 1));
   localparam logic signed [CLIP_W-1:0] DEADBAND_S  = CLIP_W'(svcs_pkg::DEADBAND);
   localparam logic [POS_W-1:0]         POS_RESET   =
      {svcs_pkg::NEUTRAL_RESET, {FRAC_BITS{1'b0}}};
   localparam logic [svcs_pkg::ACCUM_W-1:0] ACCUM_MAX = '1;

   // Input register.
   logic                                in_vld_ff;
   logic [svcs_pkg::REQ_W-1:0]          in_kind_ff;
   logic signed [svcs_pkg::CMD_W-1:0]   in_cmd_ff;
   logic [svcs_pkg::ELAPSED_W-1:0]      in_elapsed_ff;

   // Channel state.
   logic [POS_W-1:0]                    pos_ff, pos_in;
   logic [POS_W-1:0]                    target_ff, target_in;
   logic [svcs_pkg::ACCUM_W-1:0]        accum_ff, accum_in;
   logic [svcs_pkg::PULSE_W-1:0]        last_ff, last_in;

   // Result register.
   logic                                rsp_vld_ff, rsp_vld_in;
   logic [svcs_pkg::PULSE_W-1:0]        rsp_pulse_ff, rsp_pulse_in;
   logic                                rsp_neutral_ff, rsp_neutral_in;

   logic                                out_free;
   logic                                proc;
   svcs_pkg::req_kind_type              kind;

   // Command path.
   logic signed [CLIP_W-1:0]            cmd_ext;
   logic signed [CLIP_W-1:0]            lim_s;
   logic signed [CLIP_W-1:0]            cmd_clip;
   logic signed [PROD_W-1:0]            cmd_prod;
   logic signed [PROD_W-1:0]            travel_round;
   logic signed [SUM_W-1:0]             travel;
   logic signed [SUM_W-1:0]             target_sum;
   logic signed [SUM_W-1:0]             lo_s;
   logic signed [SUM_W-1:0]             hi_s;
   logic signed [SUM_W-1:0]             target_clamp;

   // Tick path.
   logic [svcs_pkg::ACCUM_W:0]          accum_sum;
   logic [svcs_pkg::ACCUM_W-1:0]        accum_sat;
   logic                                do_update;
   logic [svcs_pkg::RATE_W+svcs_pkg::ACCUM_W-1:0] slew_prod;
   logic [SLEW_W-1:0]                   max_step;
   logic                                moving_up;
   logic [POS_W-1:0]                    diff;
   logic [POS_W-1:0]                    pos_slew;
   logic [POS_W:0]                      pulse_sum;
   logic [svcs_pkg::PULSE_W-1:0]        pulse_new;

   // Terms used by the checks below.
   logic                                proc_tick;
   logic                                proc_snap;
   logic                                tick_wait;
   logic                                tick_emit;
   logic                                slew_word_ok;
   logic                                snap_ok;

   // A word moves on when the result register is empty or being drained.
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign proc       = in_vld_ff && out_free;
   assign req_tready = !in_vld_ff || out_free;
   assign kind       = svcs_pkg::req_kind_type'(in_kind_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_kind_ff    <= req_tuser;
         in_cmd_ff     <= req_tdata[svcs_pkg::CMD_W-1:0];
         in_elapsed_ff <= req_tdata[svcs_pkg::CMD_W +: svcs_pkg::ELAPSED_W];
      end
   end

   // Command shaping: deadband, limit, scale by travel with rounding, reverse,
   // offset by neutral and clamp into the allowed pulse range.
   always_comb begin
      cmd_ext = CLIP_W'(in_cmd_ff);
      lim_s   = signed'(CLIP_W'(cfg.command_limit));
      cmd_clip = cmd_ext;
      if ((cmd_ext > -DEADBAND_S) && (cmd_ext < DEADBAND_S)) begin
         cmd_clip = '0;
      end
      if (cmd_clip > lim_s) begin
         cmd_clip = lim_s;
      end
      if (cmd_clip < -lim_s) begin
         cmd_clip = -lim_s;
      end
      cmd_prod     = PROD_W'(signed'({1'b0, cfg.brake_travel})) * PROD_W'(cmd_clip);
      travel_round = (cmd_prod + TRAVEL_BIAS) >>> SHIFT;
      travel       = SUM_W'(travel_round);
      if (cfg.direction_reversed) begin
         travel = -travel;
      end
      target_sum = signed'(SUM_W'({cfg.neutral_pulse, {FRAC_BITS{1'b0}}})) + travel;
      lo_s       = signed'(SUM_W'({cfg.min_pulse, {FRAC_BITS{1'b0}}}));
      hi_s       = signed'(SUM_W'({cfg.max_pulse, {FRAC_BITS{1'b0}}}));
      if (target_sum < lo_s) begin
         target_clamp = lo_s;
      end else if (target_sum > hi_s) begin
         target_clamp = hi_s;
      end else begin
         target_clamp = target_sum;
      end
   end

   // Tick handling: saturating time accumulator and a bounded step toward
   // the target, then the half-up rounded pulse.
   always_comb begin
      accum_sum = {1'b0, accum_ff} + (svcs_pkg::ACCUM_W + 1)'(in_elapsed_ff);
      accum_sat = accum_sum[svcs_pkg::ACCUM_W] ? ACCUM_MAX
                                               : accum_sum[svcs_pkg::ACCUM_W-1:0];
      do_update = accum_sat >= svcs_pkg::ACCUM_W'(cfg.update_interval);
      slew_prod = cfg.slew_rate * accum_sat;
      max_step  = (SLEW_W'(slew_prod) << FRAC_BITS) >> RATE_FRAC;
      moving_up = target_ff >= pos_ff;
      diff      = moving_up ? (target_ff - pos_ff) : (pos_ff - target_ff);
      if (SLEW_W'(diff) > max_step) begin
         pos_slew = moving_up ? (pos_ff + max_step[POS_W-1:0])
                              : (pos_ff - max_step[POS_W-1:0]);
      end else begin
         pos_slew = target_ff;
      end
      pulse_sum = {1'b0, pos_slew} + PULSE_BIAS;
      pulse_new = pulse_sum[FRAC_BITS +: svcs_pkg::PULSE_W];
   end

   // Next state and result for the word in the input register.
   always_comb begin
      pos_in         = pos_ff;
      target_in      = target_ff;
      accum_in       = accum_ff;
      last_in        = last_ff;
      rsp_vld_in     = rsp_vld_ff && !rsp_tready;
      rsp_pulse_in   = rsp_pulse_ff;
      rsp_neutral_in = rsp_neutral_ff;
      if (proc) begin
         rsp_vld_in = 1'b0;
         case (kind)
            svcs_pkg::REQ_COMMAND: begin
               target_in = target_clamp[POS_W-1:0];
            end
            svcs_pkg::REQ_TICK: begin
               if (do_update) begin
                  accum_in = '0;
                  pos_in   = pos_slew;
                  if (pulse_new != last_ff) begin
                     last_in        = pulse_new;
                     rsp_vld_in     = 1'b1;
                     rsp_pulse_in   = pulse_new;
                     rsp_neutral_in = 1'b0;
                  end
               end else begin
                  accum_in = accum_sat;
               end
            end
            svcs_pkg::REQ_NEUTRAL: begin
               pos_in         = {cfg.neutral_pulse, {FRAC_BITS{1'b0}}};
               target_in      = {cfg.neutral_pulse, {FRAC_BITS{1'b0}}};
               last_in        = cfg.neutral_pulse;
               rsp_vld_in     = 1'b1;
               rsp_pulse_in   = cfg.neutral_pulse;
               rsp_neutral_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // State and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= POS_RESET;
         target_ff  <= POS_RESET;
         accum_ff   <= '0;
         last_ff    <= svcs_pkg::NEUTRAL_RESET;
         rsp_vld_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         target_ff  <= target_in;
         accum_ff   <= accum_in;
         last_ff    <= last_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pulse_ff   <= rsp_pulse_in;
      rsp_neutral_ff <= rsp_neutral_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = svcs_pkg::RSP_DATA_W'(rsp_pulse_ff);
   assign rsp_tuser  = rsp_neutral_ff;

   // Conditions watched by the checks.
   assign proc_tick    = proc && (kind == svcs_pkg::REQ_TICK);
   assign proc_snap    = proc && (kind == svcs_pkg::REQ_NEUTRAL);
   assign tick_wait    = proc_tick && !do_update;
   assign tick_emit    = proc_tick && do_update && (pulse_new != last_ff);
   assign slew_word_ok = rsp_vld_ff && (rsp_pulse_ff == last_ff) && !rsp_neutral_ff;
   assign snap_ok      = (pos_ff == {last_ff, {FRAC_BITS{1'b0}}}) && (target_ff == pos_ff);

   // A result word only appears after a word was processed.
   `SVCS_ASSERT_NOW(a_rsp_from_proc, $rose(rsp_vld_ff), $past(proc), "result without source word")

   // A slew result carries the newly remembered pulse width.
   `SVCS_ASSERT_NEXT(a_slew_tracks_last, tick_emit, slew_word_ok, "slew result mismatch")

   // A tick below the interval leaves the position alone.
   `SVCS_ASSERT_NEXT(a_tick_holds_pos, tick_wait, $stable(pos_ff), "position moved early")

   // A neutral snap puts the position at neutral.
   `SVCS_ASSERT_NEXT(a_neutral_snap, proc_snap, snap_ok && (last_ff == $past(cfg.neutral_pulse)), "snap missed")

endmodule

`default_nettype wire

@@ design/servo_command_slew_shaper.sv @@
// ----------------------------------------------------------------------------
// Servo command slew shaper
// One servo channel that turns commands and time ticks into pulse widths.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one word per handshake: tuser selects the kind
//   (set command, time tick, snap to neutral), tdata carries the Q1.15
//   command and the elapsed milliseconds. A set command only moves the
//   target. A tick moves the position toward the target once enough time
//   has gathered and sends a pulse word when the rounded width changes.
//   A neutral snap always sends the neutral width with the tuser flag set.
//   The rsp channel carries the pulse width in microseconds.
//   Throughput is one word per cycle while the receiver keeps up; the
//   command multiply, the slew multiply and the clamp all sit in the
//   single stage between the input register and the result register,
//   which holds each result until the receiver takes it.
//   When the receiver stalls, the pending result holds and the block still
//   takes one more word into its input register; it then waits.
//   Reset puts position and target at 1500 us, clears the time gathered
//   and loads the register reset values. The csr port is APB-style with
//   one 32-bit register per word address.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_command_slew_shaper #(
   parameter int FRAC_BITS = svcs_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Input words.
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // tdata: command_value[15:0], elapsed_ms[25:16], zero fill [31:26].
   input  wire logic [svcs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: req_type[1:0].
   input  wire logic [svcs_pkg::REQ_W-1:0]        req_tuser,
   // Result words.
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // tdata: pulse_width[11:0], zero fill [15:12].
   output logic      [svcs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // tuser: from_neutral[0].
   output logic                                   rsp_tuser,
   // Configuration port.
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [svcs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [svcs_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [svcs_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready
);

   svcs_pkg::cfg_type cfg;

   // Configuration registers.
   svcs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Shaping and slew datapath.
   svcs_core #(
      .FRAC_BITS (FRAC_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
